FILE: hdl/spectrum_band_bar_meter_defines.svh
// ---------------------------------------------------------------------------
// spectrum_band_bar_meter_defines.svh
// Assertion macros used by the checker file of the bar meter.
// ---------------------------------------------------------------------------
`ifndef SPECTRUM_BAND_BAR_METER_DEFINES_SVH
`define SPECTRUM_BAND_BAR_METER_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define SBM_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define SBM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/sbm_pkg.sv
// ---------------------------------------------------------------------------
// sbm_pkg
// Widths, reset values and controller/datapath interface types.
// ---------------------------------------------------------------------------
package sbm_pkg;

    localparam int TOP_W     = 11;   // bin index and band top
    localparam int BAND_W    = 3;
    localparam int NUM_TOPS  = 8;
    localparam int CFG_IDX_W = 3;
    localparam int MAG_W     = 32;
    localparam int SUM_W     = 42;
    localparam int MEAN_W    = 40;   // 32.8 fixed point
    localparam int FRAC_W    = 8;
    localparam int DIVD_W    = SUM_W + FRAC_W;
    localparam int SPAN_W    = TOP_W + 1;
    localparam int DCY_W     = MEAN_W + 7;  // peak * 66
    localparam int DCY_SH    = 16;
    localparam int LHS_W     = 44;   // mean * levels * 256, levels up to 16
    localparam int BAR_W     = 8;
    localparam int LVL_W     = 3;
    localparam int CNT_W     = 6;
    localparam int OUT_W     = 48;
    localparam int SIN_W     = 32;

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIVD_W - 1);

    localparam logic [TOP_W-1:0] TOP_RESET [NUM_TOPS] = '{
        11'd3, 11'd7, 11'd16, 11'd33, 11'd68, 11'd140, 11'd289, 11'd596
    };

    typedef struct packed {
        logic take;
        logic span_ld;
        logic div_step;
        logic peak_ld;
        logic peak_wr;
        logic bar_step;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic close;
        logic div_last;
        logic bar_done;
        logic out_busy;
    } t_dp_sts;

endpackage

FILE: hdl/spectrum_band_bar_meter.sv
// ---------------------------------------------------------------------------
// spectrum_band_bar_meter
// Sums FFT bins into bands, tracks a decaying per-band peak, emits bars.
// ---------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  s         in   i_s_tvalid / o_s_tready   i_s_tdata magnitude, i_s_tlast frame_end
//  m         out  o_m_tvalid / i_m_tready   o_m_tdata band, bar, band_mean
//  cfg       in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data band top
//
//  A bin that closes no band leaves o_s_tready high. A closing bin keeps
//  o_s_tready low after its beat through span, 50 steps of the one-bit
//  restoring divider, peak read and update, 1 to min(BAR_LEVELS,8) steps of
//  the bar scan, and emit; a result still held on the master side extends emit.
//  Synchronous active-low reset restores band tops and clears all peaks.
//  A held result does not block intake of bins that close no band.
// ---------------------------------------------------------------------------
module spectrum_band_bar_meter
    import sbm_pkg::*;
#(
    parameter int NUM_BANDS  = 8,
    parameter int BAR_LEVELS = 8,
    parameter int FRAME_BINS = 2048,
    parameter int FIRST_BIN  = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [SIN_W-1:0]     i_s_tdata,   // [31:0] magnitude
    input  logic                 i_s_tlast,   // frame_end
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [OUT_W-1:0]     o_m_tdata,   // [2:0] band, [10:3] bar, [42:11] band_mean
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TOP_W-1:0]     i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    sbm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sbm_datapath #(
        .NUM_BANDS  (NUM_BANDS),
        .BAR_LEVELS (BAR_LEVELS),
        .FRAME_BINS (FRAME_BINS),
        .FIRST_BIN  (FIRST_BIN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_mag       (i_s_tdata),
        .i_fend      (i_s_tlast),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

FILE: hdl/sbm_ctrl.sv
// ---------------------------------------------------------------------------
// sbm_ctrl
// Sequencer: bin intake, span, divide, peak update, bar scan, emit.
// ---------------------------------------------------------------------------
module sbm_ctrl
    import sbm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SPAN  = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_PEAK  = 7'b0001000,
        S_DECAY = 7'b0010000,
        S_BAR   = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.take = i_s_tvalid;
                if (i_s_tvalid && i_sts.close) begin
                    n_state = S_SPAN;
                end
            end
            S_SPAN: begin
                o_cmd.span_ld = 1'b1;
                n_state       = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_PEAK;
                end
            end
            S_PEAK: begin
                o_cmd.peak_ld = 1'b1;
                n_state       = S_DECAY;
            end
            S_DECAY: begin
                o_cmd.peak_wr = 1'b1;
                n_state       = S_BAR;
            end
            S_BAR: begin
                o_cmd.bar_step = 1'b1;
                if (i_sts.bar_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hdl/sbm_datapath.sv
// ---------------------------------------------------------------------------
// sbm_datapath
// Band tops, bin counter, band sum, serial divider, peak store, bar scan.
// ---------------------------------------------------------------------------
module sbm_datapath
    import sbm_pkg::*;
#(
    parameter int NUM_BANDS  = 8,
    parameter int BAR_LEVELS = 8,
    parameter int FRAME_BINS = 2048,
    parameter int FIRST_BIN  = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TOP_W-1:0]     i_cfg_data,
    input  logic [MAG_W-1:0]     i_mag,
    input  logic                 i_fend,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic                 i_m_tready,
    output logic                 o_m_tvalid,
    output logic [OUT_W-1:0]     o_m_tdata
);

    localparam int PK_AW = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam int LVL_N = (BAR_LEVELS < BAR_W) ? BAR_LEVELS : BAR_W;

    logic [TOP_W-1:0]  r_top [NUM_TOPS];
    logic [TOP_W-1:0]  r_bin_cnt;
    logic [BAND_W-1:0] r_band_now;
    logic              r_done;
    logic [SUM_W-1:0]  r_sum;

    logic [BAND_W-1:0] r_cls_band;
    logic [TOP_W-1:0]  r_cls_idx;
    logic [SPAN_W-1:0] r_span;
    logic [SPAN_W-1:0] r_rem;
    logic [DIVD_W-1:0] r_quo;
    logic [CNT_W-1:0]  r_div_cnt;

    logic [MEAN_W-1:0] r_pk_mem [NUM_BANDS];
    logic [MEAN_W-1:0] r_mean;
    logic [MEAN_W-1:0] r_old;
    logic              r_grow;
    logic [DCY_W-1:0]  r_dcy;
    logic [MEAN_W-1:0] r_peak;

    logic [LHS_W-1:0]  r_lhs;
    logic [LHS_W-1:0]  r_acc;
    logic [LVL_W-1:0]  r_lvl;
    logic [BAR_W-1:0]  r_bar;

    logic              r_out_vld;
    logic [BAND_W-1:0] r_out_band;
    logic [BAR_W-1:0]  r_out_bar;
    logic [MAG_W-1:0]  r_out_mean;

    logic [BAND_W-1:0] top_addr;
    logic [TOP_W-1:0]  top_rd;
    logic              in_band;
    logic              close;
    logic              frame_over;
    logic              last_band;
    logic [SUM_W:0]    sum_add;
    logic [SUM_W-1:0]  n_sum;
    logic [SPAN_W-1:0] start;
    logic [SPAN_W-1:0] idx_ext;
    logic [SPAN_W-1:0] n_span;
    logic [SPAN_W:0]   trial;
    logic              trial_ge;
    logic [MEAN_W-1:0] mean_sat;
    logic [MEAN_W-1:0] pk_rd;
    logic [MEAN_W-1:0] n_peak;
    logic              lit;

    // one read port on the tops: current band in intake, previous top in span
    assign top_addr = i_cmd.span_ld ? (r_cls_band - BAND_W'(1)) : r_band_now;
    assign top_rd   = r_top[top_addr];

    assign in_band    = !r_done && (r_bin_cnt >= TOP_W'(FIRST_BIN));
    assign close      = in_band && (r_bin_cnt == top_rd);
    assign frame_over = i_fend || (r_bin_cnt >= TOP_W'(FRAME_BINS - 1));
    assign last_band  = (r_band_now == BAND_W'(NUM_BANDS - 1));

    assign sum_add = {1'b0, r_sum} + (SUM_W + 1)'(i_mag);
    assign n_sum   = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];

    assign start   = (r_cls_band == '0) ? SPAN_W'(FIRST_BIN)
                                        : ({1'b0, top_rd} + SPAN_W'(1));
    assign idx_ext = {1'b0, r_cls_idx};
    assign n_span  = (idx_ext >= start) ? (idx_ext - start + SPAN_W'(1)) : SPAN_W'(1);

    assign trial    = {r_rem, r_quo[DIVD_W-1]};
    assign trial_ge = (trial >= {1'b0, r_span});

    assign mean_sat = (r_quo[DIVD_W-1:MEAN_W] != '0) ? {MEAN_W{1'b1}} : r_quo[MEAN_W-1:0];
    assign pk_rd    = r_pk_mem[r_cls_band[PK_AW-1:0]];

    assign n_peak = r_grow ? r_mean
                           : (r_old - MEAN_W'(r_dcy[DCY_W-1:DCY_SH])
                                    - MEAN_W'(r_dcy[DCY_SH-1:0] != '0));

    assign lit = (r_lhs >= r_acc);

    assign o_sts.close    = close;
    assign o_sts.div_last = (r_div_cnt == DIV_LAST);
    assign o_sts.bar_done = (r_peak == '0) || !lit || (r_lvl == LVL_W'(LVL_N - 1));
    assign o_sts.out_busy = r_out_vld && !i_m_tready;

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {(OUT_W - MAG_W - BAR_W - BAND_W)'(0), r_out_mean, r_out_bar,
                         r_out_band};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TOPS; i++) begin
                r_top[i] <= TOP_RESET[i];
            end
            for (int i = 0; i < NUM_BANDS; i++) begin
                r_pk_mem[i] <= '0;
            end
            r_bin_cnt  <= '0;
            r_band_now <= '0;
            r_done     <= 1'b0;
            r_sum      <= '0;
            r_div_cnt  <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                r_top[i_cfg_index] <= i_cfg_data;
            end
            if (i_cmd.take) begin
                if (frame_over) begin
                    r_bin_cnt  <= '0;
                    r_band_now <= '0;
                    r_done     <= 1'b0;
                    r_sum      <= '0;
                end else begin
                    r_bin_cnt <= r_bin_cnt + TOP_W'(1);
                    if (close) begin
                        r_sum <= '0;
                        if (last_band) begin
                            r_done <= 1'b1;
                        end else begin
                            r_band_now <= r_band_now + BAND_W'(1);
                        end
                    end else if (in_band) begin
                        r_sum <= n_sum;
                    end
                end
                if (close) begin
                    r_div_cnt <= '0;
                end
            end
            if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + CNT_W'(1);
            end
            if (i_cmd.peak_wr) begin
                r_pk_mem[r_cls_band[PK_AW-1:0]] <= n_peak;
            end
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && close) begin
            r_quo      <= {n_sum, FRAC_W'(0)};
            r_rem      <= '0;
            r_cls_band <= r_band_now;
            r_cls_idx  <= r_bin_cnt;
        end
        if (i_cmd.span_ld) begin
            r_span <= n_span;
        end
        if (i_cmd.div_step) begin
            r_rem <= trial_ge ? SPAN_W'(trial - {1'b0, r_span}) : trial[SPAN_W-1:0];
            r_quo <= {r_quo[DIVD_W-2:0], trial_ge};
        end
        if (i_cmd.peak_ld) begin
            r_mean <= mean_sat;
            r_old  <= pk_rd;
            r_grow <= (pk_rd < mean_sat);
            r_dcy  <= {pk_rd, 6'd0} + {6'd0, pk_rd, 1'b0};
        end
        if (i_cmd.peak_wr) begin
            r_peak <= n_peak;
            r_lhs  <= LHS_W'({r_mean[MEAN_W-1:FRAC_W], FRAC_W'(0)}) * LHS_W'(BAR_LEVELS);
            r_acc  <= '0;
            r_lvl  <= '0;
            r_bar  <= '0;
        end
        if (i_cmd.bar_step && (r_peak != '0) && lit) begin
            r_bar[r_lvl] <= 1'b1;
            r_acc        <= r_acc + LHS_W'(r_peak);
            r_lvl        <= r_lvl + LVL_W'(1);
        end
        if (i_cmd.emit) begin
            r_out_band <= r_cls_band;
            r_out_bar  <= r_bar;
            r_out_mean <= r_mean[MEAN_W-1:FRAC_W];
        end
    end

endmodule

FILE: hdl/sbm_checker.sv
// ---------------------------------------------------------------------------
// sbm_checker
// Port-level checks on result beats of the bar meter.
// ---------------------------------------------------------------------------
`include "spectrum_band_bar_meter_defines.svh"

module sbm_checker
    import sbm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [OUT_W-1:0]     o_m_tdata
);

    logic [BAR_W-1:0] bar;

    assign bar = o_m_tdata[10:3];

    `SBM_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "result beat dropped or changed while stalled")
    `SBM_ASSERT(a_pad_zero, o_m_tvalid, o_m_tdata[OUT_W-1:43] == '0, "result pad bits not zero")
    `SBM_ASSERT(a_bar_thermo, o_m_tvalid, ((bar + BAR_W'(1)) & bar) == '0, "bar is not a thermometer code")
    `SBM_ASSERT(a_dark_bar_mean, o_m_tvalid && (bar == '0), o_m_tdata[42:11] == '0, "dark bar with nonzero band mean")

endmodule

bind spectrum_band_bar_meter sbm_checker u_sbm_checker (.*);

FILE: tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the spectrum band bar meter.
// Streams magnitude bins through the slave port, rewrites the band tops
// between phases and scores each band result against a cycle-free
// prediction of sum, mean, decaying peak and thermometer bar.
// ---------------------------------------------------------------------------
module tb
    import sbm_pkg::*;
();

    localparam int BANDS     = 8;
    localparam int LEVELS    = 8;
    localparam int FRAME_LEN = 2048;
    localparam int FIRST     = 1;
    localparam int SETTLE    = 80;
    localparam logic [63:0] SUM_CAP  = (64'd1 << 42) - 64'd1;
    localparam logic [63:0] MEAN_CAP = (64'd1 << 40) - 64'd1;
    localparam logic [31:0] MAG_MAX  = 32'hFFFF_FFFF;

    typedef logic [NUM_TOPS-1:0][TOP_W-1:0] t_top_set;

    typedef struct packed {
        logic [BAND_W-1:0] band;
        logic [BAR_W-1:0]  bar;
        logic [31:0]       mean;
    } t_band_result;

    class band_meter_scoreboard;
        logic [TOP_W-1:0]  top [NUM_TOPS];
        logic [TOP_W-1:0]  bin_idx;
        logic [BAND_W-1:0] band_cur;
        bit                all_closed;
        logic [63:0]       sum_acc;
        logic [63:0]       peak [NUM_TOPS];
        t_band_result      pending [$];
        int                errors;
        int                bins_seen;
        int                results_seen;

        function new();
            top = '{11'd3, 11'd7, 11'd16, 11'd33, 11'd68, 11'd140, 11'd289, 11'd596};
            foreach (peak[k]) peak[k] = '0;
            bin_idx = '0;
            band_cur = '0;
            all_closed = 0;
            sum_acc = '0;
            errors = 0;
            bins_seen = 0;
            results_seen = 0;
        endfunction

        function void set_top(int idx, logic [TOP_W-1:0] val);
            top[idx] = val;
        endfunction

        function void note_bin(logic [31:0] mag, logic last);
            int unsigned  idx;
            int unsigned  start;
            int unsigned  span;
            int unsigned  b;
            logic [63:0]  mean;
            logic [63:0]  pk;
            logic [63:0]  whole;
            logic [7:0]   bar_v;
            t_band_result r;
            idx = bin_idx;
            bins_seen++;
            if (!all_closed && idx >= FIRST) begin
                b = band_cur;
                sum_acc = sum_acc + mag;
                if (sum_acc > SUM_CAP) sum_acc = SUM_CAP;
                if (idx == top[b]) begin
                    if (b == 0) start = FIRST;
                    else start = top[b-1] + 1;
                    span = (idx >= start) ? idx - start + 1 : 1;
                    mean = (sum_acc << 8) / span;
                    if (mean > MEAN_CAP) mean = MEAN_CAP;
                    pk = peak[b];
                    if (pk < mean) pk = mean;
                    else pk = (pk * 64'd65470) >> 16;
                    peak[b] = pk;
                    whole = mean >> 8;
                    bar_v = '0;
                    if (pk != 0) begin
                        for (int j = 0; j < LEVELS && j < 32; j++) begin
                            if (64'(LEVELS) * whole * 64'd256 >= 64'(j) * pk) begin
                                if (j < 8) bar_v[j] = 1'b1;
                            end else begin
                                break;
                            end
                        end
                    end
                    r.band = BAND_W'(b);
                    r.bar  = bar_v;
                    r.mean = whole[31:0];
                    pending.push_back(r);
                    sum_acc = '0;
                    if (b + 1 >= BANDS) all_closed = 1;
                    else band_cur = BAND_W'(b + 1);
                end
            end
            if (last || idx >= FRAME_LEN - 1) begin
                bin_idx = '0;
                band_cur = '0;
                all_closed = 0;
                sum_acc = '0;
            end else begin
                bin_idx = TOP_W'(idx + 1);
            end
        endfunction

        function void check_result(logic [OUT_W-1:0] d);
            t_band_result e;
            results_seen++;
            if (pending.size() == 0) begin
                $error("band result with no bin behind it: tdata=%h", d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[2:0] !== e.band) begin
                $error("band: expected %0d, actual %0d", e.band, d[2:0]);
                errors++;
            end
            if (d[10:3] !== e.bar) begin
                $error("bar: expected %b, actual %b", e.bar, d[10:3]);
                errors++;
            end
            if (d[42:11] !== e.mean) begin
                $error("band_mean: expected %0d, actual %0d", e.mean, d[42:11]);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [SIN_W-1:0]     i_s_tdata   = '0;   // [31:0] magnitude
    logic                 i_s_tlast   = 1'b0; // frame_end
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [OUT_W-1:0]     o_m_tdata;          // [2:0] band, [10:3] bar, [42:11] band_mean
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [TOP_W-1:0]     i_cfg_data  = '0;

    band_meter_scoreboard sb = new();
    int src_idle_pct  = 38;
    int sink_idle_pct = 83;
    int hold_left     = 0;
    int settings_done = 0;

    spectrum_band_bar_meter #(
        .NUM_BANDS (BANDS),
        .BAR_LEVELS(LEVELS),
        .FRAME_BINS(FRAME_LEN),
        .FIRST_BIN (FIRST)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // sink: score accepted beats, then pick next tready; hold off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
            if (hold_left > 0) begin
                i_m_tready <= 1'b0;
                hold_left--;
            end else begin
                i_m_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    task automatic send_bin(input logic [31:0] mag, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= mag;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_bin(mag, last);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_tops(input t_top_set t);
        for (int k = 0; k < NUM_TOPS; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(k);
            i_cfg_data  <= t[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            sb.set_top(k, t[k]);
        end
        i_cfg_valid <= 1'b0;
        settings_done++;
    endtask

    function automatic logic [31:0] rand_mag();
        case ($urandom_range(3))
            0:       return '0;
            1:       return MAG_MAX;
            2:       return $urandom_range(255);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_top_set ordered_tops();
        t_top_set t;
        int unsigned acc;
        acc = $urandom_range(1, 4);
        for (int k = 0; k < NUM_TOPS; k++) begin
            t[k] = TOP_W'(acc);
            acc += $urandom_range(1, 6);
        end
        return t;
    endfunction

    // well-formed frames with random content; some run on, some cut short
    task automatic run_frames(input int n_bins, input int frame_max);
        int sent = 0;
        int len;
        logic fl;
        while (sent < n_bins) begin
            len = $urandom_range(1, frame_max);
            for (int k = 0; k < len; k++) begin
                if (k == len - 1) fl = ($urandom_range(9) != 0);
                else fl = ($urandom_range(19) == 0);
                send_bin(rand_mag(), fl);
            end
            sent += len;
        end
    endtask

    initial begin
        t_top_set t;
        int       mx;
        int       pick;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default tops: full-scale band, decay, zero mean, never-lit peak, early end
        send_bin(32'd0, 1'b0);
        send_bin(MAG_MAX, 1'b0);
        send_bin(MAG_MAX, 1'b0);
        send_bin(MAG_MAX, 1'b1);
        send_bin(32'd0, 1'b0);
        send_bin(32'd1, 1'b0);
        send_bin(32'd1, 1'b0);
        send_bin(32'd1, 1'b1);
        for (int k = 0; k < 8; k++) send_bin(32'd0, k == 7);
        send_bin(32'd0, 1'b0);
        send_bin(MAG_MAX, 1'b0);
        send_bin(32'h8000_0000, 1'b0);
        send_bin(32'd1, 1'b0);
        send_bin(32'hAAAA_AAAA, 1'b1);
        drain();

        // tops moved under an open band: span falls back to one bin
        t = {11'd1100, 11'd1000, 11'd900, 11'd800, 11'd700, 11'd600, 11'd2, 11'd1};
        write_tops(t);
        for (int k = 0; k < 8; k++) send_bin(MAG_MAX, 1'b0);
        drain();
        t[1] = 11'd1000;
        t[2] = 11'd9;
        write_tops(t);
        send_bin(MAG_MAX, 1'b0);
        send_bin(MAG_MAX, 1'b0);
        send_bin(32'd9, 1'b1);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph / 2)
                0:       begin src_idle_pct = 38; sink_idle_pct = 83; end
                1:       begin src_idle_pct = 83; sink_idle_pct = 38; end
                default: begin src_idle_pct = 0;  sink_idle_pct = 0;  end
            endcase
            if (ph == 0 || ph == 4) begin
                for (int k = 0; k < NUM_TOPS; k++) t[k] = TOP_W'(k + 1);
            end else begin
                t = ordered_tops();
                if (ph % 2 == 1) begin
                    pick = $urandom_range(1, NUM_TOPS - 1);
                    t[pick] = TOP_W'($urandom_range(1, t[pick-1]));
                end
            end
            write_tops(t);
            mx = 0;
            for (int k = 0; k < NUM_TOPS; k++) if (t[k] > mx) mx = t[k];
            if (ph == 4) hold_left = 500;
            run_frames(67, mx + 3);
            drain();
        end

        if (sb.pending.size() != 0) begin
            $error("%0d band results never arrived", sb.pending.size());
            sb.errors++;
        end
        $display("run covered %0d bins and %0d band results over %0d top settings",
                 sb.bins_seen, sb.results_seen, settings_done);
        $display("including a collapsed span, misordered tops and a long sink hold-off");
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
